// ===== src/face_vector_match_and_track_macros.svh =====
// ============================================================================
// face_vector_match_and_track assertion macros
// Implication checks on the block clock, dropped for synthesis.
// ============================================================================
`ifndef FACE_VECTOR_MATCH_AND_TRACK_MACROS_SVH
`define FACE_VECTOR_MATCH_AND_TRACK_MACROS_SVH
`ifndef SYNTHESIS
`define FVMT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FVMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FVMT_ASSERT_NOW(lbl, ante, cons)
`define FVMT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/fvmt_pkg.sv =====
// ============================================================================
// fvmt_pkg
// Shared constants and cell control/status types.
// ============================================================================
package fvmt_pkg;
    localparam int ENTRIES    = 16;
    localparam int VECTOR_LEN = 128;
    localparam int ID_W       = 4;
    localparam int IDX_W      = 7;
    localparam int ADDR_W     = $clog2(VECTOR_LEN);
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 41;
    localparam int SQ_W       = 32;
    localparam int UNSEEN_W   = 5;
    localparam int LIM_W      = 4;
    localparam int K_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PROBE  = 2'd2;
    localparam logic [1:0] CMD_EOF    = 2'd3;

    localparam logic [1:0] EV_SHOW = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_HIDE = 2'd2;

    typedef struct packed {
        logic                    ld;
        logic                    rm;
        logic                    rd;
        logic                    acc;
        logic                    clr;
        logic                    scan_p;
        logic                    scan_e;
        logic                    abort;
        logic                    last;
        logic                    idx_ok;
        logic [ID_W-1:0]         face;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] wr_val;
        logic signed [VAL_W-1:0] prb_val;
        logic [SUM_W-1:0]        thr;
        logic [LIM_W-1:0]        limit;
    } t_cell_ctl;

    typedef struct packed {
        logic claim;
        logic tracked;
        logic hide;
    } t_cell_st;
endpackage

// ===== src/fvmt_cell.sv =====
// ============================================================================
// fvmt_cell
// One table slot: descriptor memory, distance sum, tracking state, scan token.
// ============================================================================
module fvmt_cell
    import fvmt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [ID_W-1:0] i_id,
    input  t_cell_ctl       i_ctl,
    input  logic            i_tok,
    output logic            o_tok,
    output t_cell_st        o_st
);
    logic signed [VAL_W-1:0] r_mem [VECTOR_LEN];
    logic signed [VAL_W-1:0] r_rd;
    logic [SQ_W-1:0]         r_sq;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_valid;
    logic                    r_tracked;
    logic [UNSEEN_W-1:0]     r_unseen;
    logic                    r_tok;

    logic                    sel;
    logic signed [VAL_W:0]   diff;
    logic signed [2*VAL_W+1:0] prod;
    logic [SUM_W:0]          sum_ext;
    logic                    match;
    logic                    claim;
    logic                    hide;

    assign sel     = (i_id == i_ctl.face);
    assign diff    = VAL_W'(0) + {i_ctl.prb_val[VAL_W-1], i_ctl.prb_val}
                     - {r_rd[VAL_W-1], r_rd};
    assign prod    = diff * diff;
    assign sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
    assign match   = r_valid && (r_sum <= i_ctl.thr);
    assign claim   = r_tok && i_ctl.scan_p && match;
    assign hide    = r_tok && i_ctl.scan_e && r_tracked
                     && (r_unseen > {1'b0, i_ctl.limit});

    assign o_tok        = r_tok;
    assign o_st.claim   = claim;
    assign o_st.tracked = r_tracked;
    assign o_st.hide    = hide;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld && sel && i_ctl.idx_ok) begin
            r_mem[i_ctl.addr] <= i_ctl.wr_val;
        end
        if (i_ctl.rd) begin
            r_rd <= r_mem[i_ctl.addr];
        end
        r_sq <= prod[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_valid   <= 1'b0;
            r_tracked <= 1'b0;
            r_unseen  <= '0;
            r_tok     <= 1'b0;
        end else begin
            r_tok <= i_ctl.abort ? 1'b0 : i_tok;
            if (i_ctl.ld && sel) begin
                r_valid <= i_ctl.last;
                r_sum   <= '0;
            end else if (i_ctl.rm && sel) begin
                r_valid <= 1'b0;
                r_sum   <= '0;
            end else if (i_ctl.clr) begin
                r_sum <= '0;
            end else if (i_ctl.acc && r_valid && i_ctl.idx_ok) begin
                r_sum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            end
            if (claim) begin
                r_tracked <= 1'b1;
                r_unseen  <= '0;
            end else if (hide) begin
                r_tracked <= 1'b0;
                r_unseen  <= '0;
            end else if (r_tok && i_ctl.scan_e && r_tracked && (r_unseen != '1)) begin
                r_unseen <= r_unseen + UNSEEN_W'(1);
            end
        end
    end
endmodule

// ===== src/face_vector_match_and_track.sv =====
// ============================================================================
// face_vector_match_and_track
// Face descriptor table with squared-distance matching and frame tracking.
//
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+---------------------
//  command  | i_cmd, i_face_id, i_element_*, i_last_*,   | start & !busy
//           | i_box_*                                    |
//  result   | o_event_*, o_result_face, o_known_face,    | o_strobe, 1 cycle
//           | o_last_result                              |
//  config   | i_cfg_we, i_cfg_index, i_cfg_data          | i_cfg_we
//
// Load and remove complete when accepted. A probe element runs memory read,
// square and accumulate; the last element adds a token walk through the cell
// chain. End of frame walks every cell, then flushes the last pending hide.
// Reset clears valid, sums and tracking at once; stored vectors are not cleared.
// Results cannot be stalled.
// ============================================================================
`include "face_vector_match_and_track_macros.svh"
module face_vector_match_and_track
    import fvmt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_cmd,
    input  logic [ID_W-1:0]         i_face_id,
    input  logic [IDX_W-1:0]        i_element_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic                    i_last_element,
    input  logic signed [15:0]      i_box_left,
    input  logic signed [15:0]      i_box_top,
    input  logic signed [15:0]      i_box_right,
    input  logic signed [15:0]      i_box_bottom,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [SUM_W-1:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic [1:0]              o_event_kind,
    output logic [ID_W-1:0]         o_result_face,
    output logic                    o_known_face,
    output logic signed [15:0]      o_event_x,
    output logic signed [15:0]      o_event_y,
    output logic [15:0]             o_event_width,
    output logic [15:0]             o_event_height,
    output logic                    o_last_result
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_SCANP = 3'd3;
    localparam logic [2:0] ST_SCANE = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]              r_state;
    logic [K_W-1:0]          r_k;
    logic [SUM_W-1:0]        r_thr;
    logic [LIM_W-1:0]        r_limit;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_last;
    logic                    r_idx_ok;
    logic signed [15:0]      r_left;
    logic signed [15:0]      r_top;
    logic [15:0]             r_w;
    logic [15:0]             r_h;
    logic                    r_pend;
    logic [ID_W-1:0]         r_pend_face;

    logic                    accept;
    logic                    idx_ok;
    logic                    inject;
    logic                    any_claim;
    logic                    claim_tracked;
    logic                    any_hide;
    logic                    k_end;
    logic signed [16:0]      dx;
    logic signed [16:0]      dy;
    t_cell_ctl               ctl;
    t_cell_st                st [ENTRIES];
    logic [ENTRIES-1:0]      claim_v;
    logic [ENTRIES-1:0]      trk_v;
    logic [ENTRIES-1:0]      hide_v;
    logic [ENTRIES:0]        tok;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign idx_ok = ({1'b0, i_element_index} < (IDX_W+1)'(VECTOR_LEN));
    assign k_end  = (r_k == K_W'(ENTRIES - 1));
    assign dx     = {i_box_right[15], i_box_right} - {i_box_left[15], i_box_left};
    assign dy     = {i_box_bottom[15], i_box_bottom} - {i_box_top[15], i_box_top};

    assign inject = (accept && (i_cmd == CMD_EOF))
                    || ((r_state == ST_ACC) && r_last);

    assign any_claim     = |claim_v;
    assign claim_tracked = |(claim_v & trk_v);
    assign any_hide      = |hide_v;

    always_comb begin
        ctl         = '0;
        ctl.ld      = accept && (i_cmd == CMD_LOAD);
        ctl.rm      = accept && (i_cmd == CMD_REMOVE);
        ctl.rd      = accept && (i_cmd == CMD_PROBE);
        ctl.acc     = (r_state == ST_ACC);
        ctl.clr     = (r_state == ST_SCANP) && (any_claim || k_end);
        ctl.scan_p  = (r_state == ST_SCANP);
        ctl.scan_e  = (r_state == ST_SCANE);
        ctl.abort   = (r_state == ST_SCANP) && any_claim;
        ctl.last    = i_last_element;
        ctl.idx_ok  = (r_state == ST_IDLE) ? idx_ok : r_idx_ok;
        ctl.face    = i_face_id;
        ctl.addr    = i_element_index[ADDR_W-1:0];
        ctl.wr_val  = i_element_value;
        ctl.prb_val = r_val;
        ctl.thr     = r_thr;
        ctl.limit   = r_limit;
    end

    assign tok[0] = inject;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            fvmt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_id    (ID_W'(gi)),
                .i_ctl   (ctl),
                .i_tok   (tok[gi]),
                .o_tok   (tok[gi+1]),
                .o_st    (st[gi])
            );
            assign claim_v[gi] = st[gi].claim;
            assign trk_v[gi]   = st[gi].tracked;
            assign hide_v[gi]  = st[gi].hide;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd == CMD_PROBE)) begin
            r_val    <= i_element_value;
            r_last   <= i_last_element;
            r_idx_ok <= idx_ok;
            r_left   <= i_box_left;
            r_top    <= i_box_top;
            r_w      <= (dx > 17'sd0) ? dx[15:0] : 16'd0;
            r_h      <= (dy > 17'sd0) ? dy[15:0] : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_thr       <= SUM_W'(24159191);
            r_limit     <= LIM_W'(3);
            r_pend      <= 1'b0;
            r_pend_face <= '0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == 1'b0) begin
                    r_thr <= i_cfg_data;
                end else begin
                    r_limit <= i_cfg_data[LIM_W-1:0];
                end
            end
            case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (accept && (i_cmd == CMD_PROBE)) begin
                        r_state <= ST_MUL;
                    end else if (accept && (i_cmd == CMD_EOF)) begin
                        r_state <= ST_SCANE;
                        r_pend  <= 1'b0;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_k     <= '0;
                    r_state <= r_last ? ST_SCANP : ST_IDLE;
                end
                ST_SCANP: begin
                    if (any_claim || k_end) begin
                        o_strobe       <= 1'b1;
                        o_event_kind   <= (any_claim && claim_tracked) ? EV_MOVE : EV_SHOW;
                        o_result_face  <= any_claim ? ID_W'(r_k) : '0;
                        o_known_face   <= any_claim;
                        o_event_x      <= r_left;
                        o_event_y      <= r_top;
                        o_event_width  <= r_w;
                        o_event_height <= r_h;
                        o_last_result  <= 1'b1;
                        r_state        <= ST_IDLE;
                    end else begin
                        r_k <= r_k + K_W'(1);
                    end
                end
                ST_SCANE: begin
                    if (any_hide) begin
                        r_pend      <= 1'b1;
                        r_pend_face <= ID_W'(r_k);
                        if (r_pend) begin
                            o_strobe       <= 1'b1;
                            o_event_kind   <= EV_HIDE;
                            o_result_face  <= r_pend_face;
                            o_known_face   <= 1'b1;
                            o_event_x      <= '0;
                            o_event_y      <= '0;
                            o_event_width  <= '0;
                            o_event_height <= '0;
                            o_last_result  <= 1'b0;
                        end
                    end
                    if (k_end) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_k <= r_k + K_W'(1);
                    end
                end
                ST_FLUSH: begin
                    if (r_pend) begin
                        o_strobe       <= 1'b1;
                        o_event_kind   <= EV_HIDE;
                        o_result_face  <= r_pend_face;
                        o_known_face   <= 1'b1;
                        o_event_x      <= '0;
                        o_event_y      <= '0;
                        o_event_width  <= '0;
                        o_event_height <= '0;
                        o_last_result  <= 1'b1;
                    end
                    r_pend  <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `FVMT_ASSERT_NOW(a_hide_no_box, o_strobe && (o_event_kind == EV_HIDE), o_known_face && (o_event_x == 16'sd0) && (o_event_width == 16'd0))
    `FVMT_ASSERT_NOW(a_unknown_show, o_strobe && !o_known_face, (o_result_face == '0) && (o_event_kind == EV_SHOW))
    `FVMT_ASSERT_NEXT(a_probe_single, o_strobe && (o_event_kind != EV_HIDE), !o_strobe)
    `FVMT_ASSERT_NOW(a_one_claim, r_state == ST_SCANP, $onehot0(claim_v))
endmodule

// ===== sim/fvmt_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// fvmt_tb_pkg
// Register indexes and the event word type shared by the bench files.
// ----------------------------------------------------------------------------
package fvmt_tb_pkg;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_LIFETIME  = 1'b1;
    localparam int   MAX_HIDES     = 16;
    localparam int   UNSEEN_SAT    = 31;
    localparam logic [40:0] THRESHOLD_DEFAULT = 41'd24159191;
    localparam logic [3:0]  LIFETIME_DEFAULT  = 4'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  face;
        logic        known;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic        last;
    } t_face_event;
endpackage

// ===== sim/face_vector_match_and_track_checker.sv =====
// ----------------------------------------------------------------------------
// face_vector_match_and_track_checker
// Watches the command, config and event ports, tracks the face table and
// tracking state, and compares every event word with the predicted one.
// ----------------------------------------------------------------------------
module face_vector_match_and_track_checker
    import fvmt_pkg::*;
    import fvmt_tb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              i_cmd,
    input  logic [ID_W-1:0]         i_face_id,
    input  logic [IDX_W-1:0]        i_element_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic                    i_last_element,
    input  logic signed [15:0]      i_box_left,
    input  logic signed [15:0]      i_box_top,
    input  logic signed [15:0]      i_box_right,
    input  logic signed [15:0]      i_box_bottom,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [SUM_W-1:0]        i_cfg_data,
    input  logic                    o_strobe,
    input  logic [1:0]              o_event_kind,
    input  logic [ID_W-1:0]         o_result_face,
    input  logic                    o_known_face,
    input  logic signed [15:0]      o_event_x,
    input  logic signed [15:0]      o_event_y,
    input  logic [15:0]             o_event_width,
    input  logic [15:0]             o_event_height,
    input  logic                    o_last_result,
    output int                      fail_count,
    output int                      events_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [15:0] face_table [ENTRIES][VECTOR_LEN];
    logic               slot_valid [ENTRIES];
    logic [SUM_W-1:0]   dist_sum   [ENTRIES];
    logic               tracked    [ENTRIES];
    logic [4:0]         unseen     [ENTRIES];
    logic [SUM_W-1:0]   threshold;
    logic [3:0]         lifetime;
    t_face_event        expected_events [$];

    initial fail_count = 0;
    assign events_pending = expected_events.size();

    function automatic logic [15:0] span(logic signed [15:0] lo, logic signed [15:0] hi);
        logic signed [16:0] d;
        d = 17'(hi) - 17'(lo);
        return (hi > lo) ? d[15:0] : 16'd0;
    endfunction

    task automatic mismatch(string field, logic [15:0] exp_v, logic [15:0] act_v);
        $error("%s: expected %0h, got %0h", field, exp_v, act_v);
        fail_count++;
    endtask

    task automatic check_event();
        t_face_event e;
        if (expected_events.size() == 0) begin
            $error("event word with none expected: kind %0d face %0d",
                   o_event_kind, o_result_face);
            fail_count++;
            return;
        end
        e = expected_events.pop_front();
        if (o_event_kind !== e.kind) mismatch("event_kind", 16'(e.kind), 16'(o_event_kind));
        if (o_result_face !== e.face) mismatch("result_face", 16'(e.face), 16'(o_result_face));
        if (o_known_face !== e.known) mismatch("known_face", 16'(e.known), 16'(o_known_face));
        if (o_event_x !== e.x) mismatch("event_x", e.x, o_event_x);
        if (o_event_y !== e.y) mismatch("event_y", e.y, o_event_y);
        if (o_event_width !== e.w) mismatch("event_width", e.w, o_event_width);
        if (o_event_height !== e.h) mismatch("event_height", e.h, o_event_height);
        if (o_last_result !== e.last) mismatch("last_result", 16'(e.last), 16'(o_last_result));
    endtask

    task automatic predict_word();
        t_face_event e;
        logic signed [16:0] d;
        logic [16:0]        m;
        logic [SUM_W:0]     s;
        int                 hit;
        int                 n;
        case (i_cmd)
            CMD_LOAD: begin
                face_table[i_face_id][i_element_index] = i_element_value;
                dist_sum[i_face_id] = '0;
                slot_valid[i_face_id] = i_last_element;
            end
            CMD_REMOVE: begin
                slot_valid[i_face_id] = 1'b0;
                dist_sum[i_face_id] = '0;
            end
            CMD_PROBE: begin
                for (int k = 0; k < ENTRIES; k++) begin
                    if (slot_valid[k]) begin
                        d = 17'(i_element_value) - 17'(face_table[k][i_element_index]);
                        m = d[16] ? 17'(-d) : 17'(d);
                        s = 42'(dist_sum[k]) + 42'(34'(m) * 34'(m));
                        dist_sum[k] = s[SUM_W] ? '1 : s[SUM_W-1:0];
                    end
                end
                if (i_last_element) begin
                    hit = -1;
                    for (int k = 0; k < ENTRIES; k++)
                        if (hit < 0 && slot_valid[k] && dist_sum[k] <= threshold) hit = k;
                    e.x = i_box_left;
                    e.y = i_box_top;
                    e.w = span(i_box_left, i_box_right);
                    e.h = span(i_box_top, i_box_bottom);
                    e.last = 1'b1;
                    if (hit >= 0) begin
                        e.kind = tracked[hit] ? EV_MOVE : EV_SHOW;
                        e.face = 4'(hit);
                        e.known = 1'b1;
                        tracked[hit] = 1'b1;
                        unseen[hit] = '0;
                    end else begin
                        e.kind = EV_SHOW;
                        e.face = '0;
                        e.known = 1'b0;
                    end
                    expected_events.insert(expected_events.size(), e);
                    for (int k = 0; k < ENTRIES; k++) dist_sum[k] = '0;
                end
            end
            CMD_EOF: begin
                n = 0;
                for (int k = 0; k < ENTRIES; k++) begin
                    if (!tracked[k]) continue;
                    if (unseen[k] > 5'(lifetime)) begin
                        if (n >= MAX_HIDES) continue;
                        e = '{EV_HIDE, 4'(k), 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                        expected_events.insert(expected_events.size(), e);
                        n++;
                        tracked[k] = 1'b0;
                        unseen[k] = '0;
                    end else if (unseen[k] < UNSEEN_SAT) begin
                        unseen[k]++;
                    end
                end
                if (n > 0) expected_events[expected_events.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                slot_valid[k] = 1'b0;
                dist_sum[k] = '0;
                tracked[k] = 1'b0;
                unseen[k] = '0;
            end
            threshold = THRESHOLD_DEFAULT;
            lifetime = LIFETIME_DEFAULT;
            expected_events.delete();
        end else begin
            if (o_strobe) check_event();
            if (i_cfg_we) begin
                if (i_cfg_index == REG_THRESHOLD) threshold = i_cfg_data;
                else lifetime = i_cfg_data[3:0];
            end
            if (start && !busy) predict_word();
        end
    end
endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Face match and track bench: fills the face table, runs directed corner
// words, then random load/remove/probe/end-of-frame traffic under several
// threshold and lifetime settings; the checker scores every event word.
// ----------------------------------------------------------------------------
module tb;
    import fvmt_pkg::*;
    import fvmt_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // probes only touch the first FILL_LEN elements, all written up front
    localparam int FILL_LEN = 8;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_cmd = CMD_LOAD;
    logic [ID_W-1:0]         i_face_id = '0;
    logic [IDX_W-1:0]        i_element_index = '0;
    logic signed [VAL_W-1:0] i_element_value = '0;
    logic                    i_last_element = 1'b0;
    logic signed [15:0]      i_box_left = '0;
    logic signed [15:0]      i_box_top = '0;
    logic signed [15:0]      i_box_right = '0;
    logic signed [15:0]      i_box_bottom = '0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_index = REG_THRESHOLD;
    logic [SUM_W-1:0]        i_cfg_data = '0;
    logic                    o_strobe;
    logic [1:0]              o_event_kind;
    logic [ID_W-1:0]         o_result_face;
    logic                    o_known_face;
    logic signed [15:0]      o_event_x;
    logic signed [15:0]      o_event_y;
    logic [15:0]             o_event_width;
    logic [15:0]             o_event_height;
    logic                    o_last_result;
    int                      fail_count;
    int                      events_pending;

    logic signed [15:0] shadow_table [ENTRIES][VECTOR_LEN];
    bit                 calm = 1'b1;

    always #1 i_clk = ~i_clk;

    face_vector_match_and_track dut (.*);
    face_vector_match_and_track_checker checker_i (.*);

    task automatic send_word(logic [1:0] cmd, logic [3:0] face, logic [6:0] idx,
                             logic signed [15:0] val, logic last,
                             logic signed [15:0] l, logic signed [15:0] t,
                             logic signed [15:0] r, logic signed [15:0] b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_face_id <= face;
        i_element_index <= idx;
        i_element_value <= val;
        i_last_element <= last;
        i_box_left <= l;
        i_box_top <= t;
        i_box_right <= r;
        i_box_bottom <= b;
        if (cmd == CMD_LOAD) shadow_table[face][idx] = val;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (events_pending != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [SUM_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_box();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic probe_run();
        int                 tgt;
        int                 len;
        int                 noise;
        logic [6:0]         idx;
        logic signed [16:0] v;
        tgt = $urandom_range(0, ENTRIES - 1);
        len = $urandom_range(1, 6);
        noise = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            idx = 7'($urandom_range(0, FILL_LEN - 1));
            case (noise)
                0: v = 17'(shadow_table[tgt][idx]);
                1: v = 17'(shadow_table[tgt][idx]) + $signed(17'($urandom_range(0, 1200))) - 600;
                2: v = 17'(shadow_table[tgt][idx]) + $signed(17'($urandom_range(0, 8000))) - 4000;
                default: v = 17'($signed(16'($urandom)));
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_word(CMD_PROBE, 4'($urandom), idx, v[15:0], k == len - 1,
                      rand_box(), rand_box(), rand_box(), rand_box());
        end
    endtask

    task automatic random_traffic(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) probe_run();
            else if (pick < 75)
                send_word(CMD_LOAD, 4'($urandom), 7'($urandom), 16'($urandom),
                          $urandom_range(0, 2) != 0, 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            else if (pick < 83)
                send_word(CMD_REMOVE, 4'($urandom), 7'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            else
                send_word(CMD_EOF, 4'($urandom), 7'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // every probed element written once so no probe reads an empty one
        for (int f = 0; f < ENTRIES; f++)
            for (int j = 0; j < FILL_LEN; j++)
                send_word(CMD_LOAD, 4'(f), 7'(j), 16'($urandom), 1'b0, '0, '0, '0, '0);
        calm = 1'b0;

        send_word(CMD_LOAD, 4'd0, 7'd0, 16'sh8000, 1'b1, '0, '0, '0, '0);
        send_word(CMD_LOAD, 4'd15, 7'd7, 16'sh7FFF, 1'b1, '0, '0, '0, '0);
        send_word(CMD_PROBE, 4'd0, 7'd7, 16'sh7FFF, 1'b1,
                  16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_word(CMD_PROBE, 4'd0, 7'd7, 16'sh7FFF, 1'b1,
                  16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_word(CMD_PROBE, 4'd0, 7'd0, 16'sh7FFF, 1'b0, '0, '0, '0, '0);
        send_word(CMD_PROBE, 4'd0, 7'd7, 16'sh8000, 1'b1, 16'sd5, 16'sd5, 16'sd5, 16'sd6);
        send_word(CMD_PROBE, 4'd0, 7'd0, 16'sh8000, 1'b1, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_word(CMD_REMOVE, 4'd0, 7'd0, '0, 1'b0, '0, '0, '0, '0);
        send_word(CMD_LOAD, 4'd15, 7'd3, 16'sd100, 1'b0, '0, '0, '0, '0);
        send_word(CMD_PROBE, 4'd0, 7'd3, 16'sd100, 1'b1, '0, '0, '0, '0);
        repeat (6) send_word(CMD_EOF, '0, '0, '0, 1'b0, '0, '0, '0, '0);
        drain();

        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_LIFETIME, 4'd0);
        random_traffic(25);
        drain();
        write_reg(REG_THRESHOLD, '1);
        write_reg(REG_LIFETIME, 4'd15);
        random_traffic(25);
        drain();
        write_reg(REG_THRESHOLD, 41'($urandom_range(0, 200000000)));
        write_reg(REG_LIFETIME, 4'($urandom));
        random_traffic(25);
        drain();
        write_reg(REG_THRESHOLD, THRESHOLD_DEFAULT * 4);
        write_reg(REG_LIFETIME, 4'd1);
        random_traffic(10);
        calm = 1'b1;
        random_traffic(10);
        drain();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/fvmt_pkg.sv
src/fvmt_cell.sv
src/face_vector_match_and_track.sv
sim/fvmt_tb_pkg.sv
sim/face_vector_match_and_track_checker.sv
sim/tb.sv
